@@ rtl/gdfs_pkg.sv @@
// Shared types, constants and helpers for the depth-first search block.
package gdfs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_ARCS     = 1024;

    localparam int VTX_W  = 7;
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int SP_W   = $clog2(MAX_VERTICES + 1);
    localparam int SLOT_W = $clog2(MAX_ARCS);
    localparam int LINK_W = $clog2(MAX_ARCS + 1);
    localparam int CNT_W  = 11;
    localparam int TIME_W = 8;
    localparam int STK_W  = VTX_W + LINK_W;
    localparam int DISC_W = VTX_W + TIME_W;

    localparam logic [1:0] MODE_ARC   = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_ORDER = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [VTX_W-1:0] VCOUNT_RESET = VTX_W'(64);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ERR,
        S_INS_HEAD, S_INS_HWAIT, S_INS_WALK, S_INS_WRITE, S_INS_LINK,
        S_DISC, S_DISC_W, S_STEP, S_STEP_W, S_POP_W, S_ORD_END,
        S_EM_RD, S_EM_RD2, S_EM_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_DECODE, OP_ERR,
        OP_INS_HEAD, OP_INS_HWAIT, OP_INS_WALK, OP_INS_WRITE, OP_INS_LINK,
        OP_DISC, OP_DISC_W, OP_STEP, OP_STEP_W, OP_POP_W, OP_ORD_END,
        OP_EM_RD, OP_EM_RD2, OP_EM_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       bad_add;
        logic       full;
        logic       bad_a;
        logic       white_a;
        logic       last;
        logic       link_zero;
        logic       walk_stop;
        logic       second_pending;
        logic       cur_zero;
        logic       sp_one;
        logic       push_ok;
        logic       flen_zero;
        logic       emit_last;
        logic       out_free;
    } dp_status_t;

    // vertex number (1-based) to table index
    function automatic logic [VIDX_W-1:0] vidx(input logic [VTX_W-1:0] v);
        logic [VTX_W-1:0] t;
        t = v - VTX_W'(1);
        return t[VIDX_W-1:0];
    endfunction

    // count to index of its last element
    function automatic logic [VIDX_W-1:0] sidx(input logic [SP_W-1:0] n);
        logic [SP_W-1:0] t;
        t = n - SP_W'(1);
        return t[VIDX_W-1:0];
    endfunction

    // link (slot plus one) to slot
    function automatic logic [SLOT_W-1:0] slot_of(input logic [LINK_W-1:0] l);
        logic [LINK_W-1:0] t;
        t = l - LINK_W'(1);
        return t[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/gdfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gdfs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gdfs_ctrl.sv @@
// Sequencer for graph loading, the depth-first walk and result emission.
module gdfs_ctrl import gdfs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.op       = OP_IDLE;
        cmd.load_in  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.op      = OP_IDLE;
                cmd.load_in = s_valid;
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                cmd.op = OP_DECODE;
                case (status.mode)
                    MODE_ARC, MODE_EDGE: begin
                        if (status.bad_add || status.full) state_next = S_ERR;
                        else state_next = S_INS_HEAD;
                    end
                    MODE_ORDER: begin
                        if (status.bad_a) state_next = S_ERR;
                        else if (status.white_a) state_next = S_DISC;
                        else state_next = S_ORD_END;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ERR: begin
                cmd.op       = OP_ERR;
                cmd.out_load = status.out_free;
                if (status.out_free) state_next = S_IDLE;
            end
            S_INS_HEAD: begin
                cmd.op     = OP_INS_HEAD;
                state_next = S_INS_HWAIT;
            end
            S_INS_HWAIT: begin
                cmd.op     = OP_INS_HWAIT;
                state_next = status.link_zero ? S_INS_WRITE : S_INS_WALK;
            end
            S_INS_WALK: begin
                cmd.op = OP_INS_WALK;
                if (status.walk_stop) state_next = S_INS_WRITE;
            end
            S_INS_WRITE: begin
                cmd.op     = OP_INS_WRITE;
                state_next = S_INS_LINK;
            end
            S_INS_LINK: begin
                cmd.op     = OP_INS_LINK;
                state_next = status.second_pending ? S_INS_HEAD : S_IDLE;
            end
            S_DISC: begin
                cmd.op     = OP_DISC;
                state_next = S_DISC_W;
            end
            S_DISC_W: begin
                cmd.op     = OP_DISC_W;
                state_next = S_STEP;
            end
            S_STEP: begin
                cmd.op = OP_STEP;
                if (!status.cur_zero) state_next = S_STEP_W;
                else if (status.sp_one) state_next = S_ORD_END;
                else state_next = S_POP_W;
            end
            S_STEP_W: begin
                cmd.op     = OP_STEP_W;
                state_next = status.push_ok ? S_DISC : S_STEP;
            end
            S_POP_W: begin
                cmd.op     = OP_POP_W;
                state_next = S_STEP;
            end
            S_ORD_END: begin
                cmd.op = OP_ORD_END;
                if (!status.last || status.flen_zero) state_next = S_IDLE;
                else state_next = S_EM_RD;
            end
            S_EM_RD: begin
                cmd.op     = OP_EM_RD;
                state_next = S_EM_RD2;
            end
            S_EM_RD2: begin
                cmd.op     = OP_EM_RD2;
                state_next = S_EM_OUT;
            end
            S_EM_OUT: begin
                cmd.op       = OP_EM_OUT;
                cmd.out_load = status.out_free;
                if (status.out_free) state_next = status.emit_last ? S_IDLE : S_EM_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/gdfs_datapath.sv @@
// Adjacency store, walk stack, per-vertex records and result register.
module gdfs_datapath import gdfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [VTX_W-1:0]  vertex_count,
    input  logic [1:0]        s_mode,
    input  logic [VTX_W-1:0]  s_first_vertex,
    input  logic [VTX_W-1:0]  s_second_vertex,
    input  logic              s_order_last,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [1:0]        m_status,
    output logic [VTX_W-1:0]  m_vertex,
    output logic [TIME_W-1:0] m_discover_time,
    output logic [TIME_W-1:0] m_finish_time,
    output logic [VTX_W-1:0]  m_parent_vertex,
    output logic [CNT_W-1:0]  m_edge_count,
    output logic              m_run_last
);

    // transaction fields
    logic [1:0]        mode_reg;
    logic [VTX_W-1:0]  a_reg, b_reg;
    logic              last_reg;
    // insertion
    logic [VTX_W-1:0]  u_reg, v_reg;
    logic              second_reg;
    logic [LINK_W-1:0] link_reg;
    logic              prev_head_reg;
    logic [SLOT_W-1:0] prev_slot_reg;
    logic [LINK_W-1:0] arcs_used_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic              head_vld_q_reg;
    // walk
    logic              run_active_reg;
    logic [MAX_VERTICES-1:0] vis_valid_reg;
    logic [TIME_W-1:0] time_reg;
    logic [SP_W-1:0]   sp_reg, flen_reg, idx_reg;
    logic [VTX_W-1:0]  top_vtx_reg, w_reg, par_reg, vout_reg;
    logic [LINK_W-1:0] top_cur_reg;
    logic [1:0]        err_code_reg;
    // result register
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [VTX_W-1:0]  m_vertex_reg, m_parent_reg;
    logic [TIME_W-1:0] m_disc_reg, m_fin_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic              m_last_reg;

    // RAM ports
    logic              head_we, head_re;
    logic [VIDX_W-1:0] head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rd;
    logic              nb_we, nx_we, arc_re;
    logic [SLOT_W-1:0] nb_waddr, nx_waddr, arc_raddr;
    logic [VTX_W-1:0]  nb_wdata, nb_rd;
    logic [LINK_W-1:0] nx_wdata, nx_rd;
    logic              disc_we, fin_we, rec_re;
    logic [VIDX_W-1:0] disc_waddr, fin_waddr, rec_raddr;
    logic [DISC_W-1:0] disc_wdata, disc_rd;
    logic [TIME_W-1:0] fin_wdata, fin_rd;
    logic              stk_we, stk_re;
    logic [VIDX_W-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0]  stk_wdata, stk_rd;
    logic              ord_we, ord_re;
    logic [VIDX_W-1:0] ord_waddr, ord_raddr;
    logic [VTX_W-1:0]  ord_wdata, ord_rd;

    logic [VTX_W-1:0]  act_cnt;
    logic              a_ok, b_ok, nb_ok, flen_room;
    logic [LINK_W:0]   need_total;
    logic [LINK_W-1:0] head_eff, new_link;
    logic [TIME_W-1:0] time_inc;
    logic              out_free;

    assign act_cnt  = (vertex_count > VTX_W'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES)
                                                           : vertex_count;
    assign a_ok     = (a_reg != '0) && (a_reg <= act_cnt);
    assign b_ok     = (b_reg != '0) && (b_reg <= act_cnt);
    assign nb_ok    = (nb_rd != '0) && (nb_rd <= VTX_W'(MAX_VERTICES));
    assign need_total = {1'b0, arcs_used_reg}
                      + ((mode_reg == MODE_EDGE) ? (LINK_W+1)'(2) : (LINK_W+1)'(1));
    assign head_eff = head_vld_q_reg ? head_rd : '0;
    assign new_link = arcs_used_reg + LINK_W'(1);
    assign time_inc = time_reg + TIME_W'(1);
    assign flen_room = flen_reg < SP_W'(MAX_VERTICES);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        status.mode           = mode_reg;
        status.bad_add        = !(a_ok && b_ok);
        status.full           = need_total > (LINK_W+1)'(MAX_ARCS);
        status.bad_a          = !a_ok;
        status.white_a        = !run_active_reg || !vis_valid_reg[vidx(a_reg)];
        status.last           = last_reg;
        status.link_zero      = (head_eff == '0);
        status.walk_stop      = (v_reg < nb_rd) || (nx_rd == '0);
        status.second_pending = (mode_reg == MODE_EDGE) && !second_reg;
        status.cur_zero       = (top_cur_reg == '0);
        status.sp_one         = (sp_reg == SP_W'(1));
        status.push_ok        = nb_ok && !vis_valid_reg[vidx(nb_rd)]
                              && (sp_reg < SP_W'(MAX_VERTICES));
        status.flen_zero      = (flen_reg == '0);
        status.emit_last      = (idx_reg == '0);
        status.out_free       = out_free;
    end

    always_comb begin
        head_we = 1'b0; head_waddr = vidx(u_reg); head_wdata = new_link;
        head_re = 1'b0; head_raddr = vidx(u_reg);
        nb_we = 1'b0; nb_waddr = arcs_used_reg[SLOT_W-1:0]; nb_wdata = v_reg;
        nx_we = 1'b0; nx_waddr = arcs_used_reg[SLOT_W-1:0]; nx_wdata = link_reg;
        arc_re = 1'b0; arc_raddr = slot_of(top_cur_reg);
        disc_we = 1'b0; disc_waddr = vidx(w_reg); disc_wdata = {par_reg, time_inc};
        fin_we = 1'b0; fin_waddr = vidx(top_vtx_reg); fin_wdata = time_inc;
        rec_re = 1'b0; rec_raddr = vidx(ord_rd);
        stk_we = 1'b0; stk_waddr = sidx(sp_reg); stk_wdata = {top_vtx_reg, top_cur_reg};
        stk_re = 1'b0; stk_raddr = sidx(sp_reg - SP_W'(1));
        ord_we = 1'b0; ord_waddr = flen_reg[VIDX_W-1:0]; ord_wdata = top_vtx_reg;
        ord_re = 1'b0; ord_raddr = sidx(idx_reg);
        case (cmd.op)
            OP_INS_HEAD: head_re = 1'b1;
            OP_INS_HWAIT: begin
                arc_re    = 1'b1;
                arc_raddr = slot_of(head_eff);
            end
            OP_INS_WALK: begin
                arc_re    = 1'b1;
                arc_raddr = slot_of(nx_rd);
            end
            OP_INS_WRITE: begin
                nb_we = 1'b1;
                nx_we = 1'b1;
            end
            OP_INS_LINK: begin
                if (prev_head_reg) begin
                    head_we = 1'b1;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = prev_slot_reg;
                    nx_wdata = new_link;
                end
            end
            OP_DISC: begin
                head_re    = 1'b1;
                head_raddr = vidx(w_reg);
                disc_we    = 1'b1;
                stk_we     = (sp_reg != '0);
            end
            OP_STEP: begin
                if (top_cur_reg != '0) begin
                    arc_re = 1'b1;
                end else begin
                    fin_we = 1'b1;
                    ord_we = flen_room;
                    stk_re = (sp_reg > SP_W'(1));
                end
            end
            OP_EM_RD: ord_re = 1'b1;
            OP_EM_RD2: rec_re = 1'b1;
            default: ;
        endcase
    end

    gdfs_ram #(.DATA_W(LINK_W), .DEPTH(MAX_VERTICES)) u_head_ram (
        .aclk, .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
        .rd_en(head_re), .rd_addr(head_raddr), .rd_data(head_rd));
    gdfs_ram #(.DATA_W(VTX_W), .DEPTH(MAX_ARCS)) u_nb_ram (
        .aclk, .wr_en(nb_we), .wr_addr(nb_waddr), .wr_data(nb_wdata),
        .rd_en(arc_re), .rd_addr(arc_raddr), .rd_data(nb_rd));
    gdfs_ram #(.DATA_W(LINK_W), .DEPTH(MAX_ARCS)) u_nx_ram (
        .aclk, .wr_en(nx_we), .wr_addr(nx_waddr), .wr_data(nx_wdata),
        .rd_en(arc_re), .rd_addr(arc_raddr), .rd_data(nx_rd));
    gdfs_ram #(.DATA_W(DISC_W), .DEPTH(MAX_VERTICES)) u_disc_ram (
        .aclk, .wr_en(disc_we), .wr_addr(disc_waddr), .wr_data(disc_wdata),
        .rd_en(rec_re), .rd_addr(rec_raddr), .rd_data(disc_rd));
    gdfs_ram #(.DATA_W(TIME_W), .DEPTH(MAX_VERTICES)) u_fin_ram (
        .aclk, .wr_en(fin_we), .wr_addr(fin_waddr), .wr_data(fin_wdata),
        .rd_en(rec_re), .rd_addr(rec_raddr), .rd_data(fin_rd));
    gdfs_ram #(.DATA_W(STK_W), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .aclk, .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
        .rd_en(stk_re), .rd_addr(stk_raddr), .rd_data(stk_rd));
    gdfs_ram #(.DATA_W(VTX_W), .DEPTH(MAX_VERTICES)) u_ord_ram (
        .aclk, .wr_en(ord_we), .wr_addr(ord_waddr), .wr_data(ord_wdata),
        .rd_en(ord_re), .rd_addr(ord_raddr), .rd_data(ord_rd));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arcs_used_reg  <= '0;
            size_reg       <= '0;
            head_valid_reg <= '0;
            run_active_reg <= 1'b0;
            vis_valid_reg  <= '0;
            time_reg       <= '0;
            sp_reg         <= '0;
            flen_reg       <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            case (cmd.op)
                OP_DECODE: begin
                    if (mode_reg == MODE_CLEAR) begin
                        head_valid_reg <= '0;
                        arcs_used_reg  <= '0;
                        size_reg       <= '0;
                        run_active_reg <= 1'b0;
                    end else if (mode_reg == MODE_ORDER) begin
                        if (!run_active_reg) begin
                            vis_valid_reg <= '0;
                            time_reg      <= '0;
                            flen_reg      <= '0;
                        end
                        // a bad root ends the run
                        run_active_reg <= a_ok;
                        sp_reg <= '0;
                    end
                end
                OP_INS_LINK: begin
                    if (prev_head_reg) head_valid_reg[vidx(u_reg)] <= 1'b1;
                    arcs_used_reg <= new_link;
                    if (!status.second_pending) size_reg <= size_reg + CNT_W'(1);
                end
                OP_DISC: begin
                    vis_valid_reg[vidx(w_reg)] <= 1'b1;
                    time_reg <= time_inc;
                end
                OP_DISC_W: sp_reg <= sp_reg + SP_W'(1);
                OP_STEP: begin
                    if (top_cur_reg == '0) begin
                        time_reg <= time_inc;
                        if (flen_room) flen_reg <= flen_reg + SP_W'(1);
                        sp_reg <= sp_reg - SP_W'(1);
                    end
                end
                OP_ORD_END: begin
                    if (last_reg) run_active_reg <= 1'b0;
                    idx_reg <= flen_reg;
                end
                OP_EM_RD: idx_reg <= idx_reg - SP_W'(1);
                default: ;
            endcase
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_mode;
            a_reg    <= s_first_vertex;
            b_reg    <= s_second_vertex;
            last_reg <= s_order_last;
        end
        if (head_re) head_vld_q_reg <= head_valid_reg[head_raddr];
        case (cmd.op)
            OP_DECODE: begin
                u_reg        <= a_reg;
                v_reg        <= b_reg;
                second_reg   <= 1'b0;
                w_reg        <= a_reg;
                par_reg      <= '0;
                err_code_reg <= (mode_reg == MODE_ORDER || !(a_ok && b_ok)) ? ST_RANGE
                                                                           : ST_FULL;
            end
            OP_INS_HWAIT: begin
                link_reg      <= head_eff;
                prev_head_reg <= 1'b1;
            end
            OP_INS_WALK: begin
                if (!(v_reg < nb_rd)) begin
                    prev_head_reg <= 1'b0;
                    prev_slot_reg <= slot_of(link_reg);
                    link_reg      <= nx_rd;
                end
            end
            OP_INS_LINK: begin
                if (status.second_pending) begin
                    second_reg <= 1'b1;
                    u_reg      <= v_reg;
                    v_reg      <= u_reg;
                end
            end
            OP_DISC_W: begin
                top_vtx_reg <= w_reg;
                top_cur_reg <= head_eff;
            end
            OP_POP_W: {top_vtx_reg, top_cur_reg} <= stk_rd;
            OP_STEP_W: begin
                top_cur_reg <= nx_rd;
                w_reg       <= nb_rd;
                par_reg     <= top_vtx_reg;
            end
            OP_EM_RD2: vout_reg <= ord_rd;
            default: ;
        endcase
        if (cmd.out_load) begin
            m_count_reg <= size_reg;
            if (cmd.op == OP_ERR) begin
                m_status_reg <= err_code_reg;
                m_vertex_reg <= '0;
                m_disc_reg   <= '0;
                m_fin_reg    <= '0;
                m_parent_reg <= '0;
                m_last_reg   <= 1'b1;
            end else begin
                m_status_reg <= ST_OK;
                m_vertex_reg <= vout_reg;
                m_disc_reg   <= disc_rd[TIME_W-1:0];
                m_fin_reg    <= fin_rd;
                m_parent_reg <= disc_rd[DISC_W-1:TIME_W];
                m_last_reg   <= (idx_reg == '0);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_vertex        = m_vertex_reg;
    assign m_discover_time = m_disc_reg;
    assign m_finish_time   = m_fin_reg;
    assign m_parent_vertex = m_parent_reg;
    assign m_edge_count    = m_count_reg;
    assign m_run_last      = m_last_reg;

endmodule

@@ rtl/graph_depth_first_search.sv @@
// Depth-first search block: top level with configuration register.
//
// Input channel (s_*): mode 0 adds an arc, 1 an undirected edge, 3 clears the
// graph, 2 feeds the next root of the DFS order list (s_order_last on the
// final one). Adds and clears give no result unless they fail; a failure
// gives one error transaction with m_run_last set.
// Output channel (m_*): after the last order vertex, one transaction per
// visited vertex in decreasing finish time, m_run_last on the final one.
// One transaction is in flight at a time. An arc add walks its adjacency list
// with one arc RAM read per cycle; an edge add also walks the second list.
// An order vertex costs a stack/adjacency RAM round trip for each vertex
// discovered and each arc followed. Emission reads the order RAM and then the
// record RAMs for each vertex.
// Reset empties all lists using per-entry valid flags; no clearing pass.
// vertex_count resets to 64 and is written at APB address 0; write it only
// while the block is idle, which the block itself does not enforce.
// A stalled m_ready holds the result register; the sequencer waits on it.
module graph_depth_first_search import gdfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [VTX_W-1:0]  s_first_vertex,
    input  logic [VTX_W-1:0]  s_second_vertex,
    input  logic              s_order_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [VTX_W-1:0]  m_vertex,
    output logic [TIME_W-1:0] m_discover_time,
    output logic [TIME_W-1:0] m_finish_time,
    output logic [VTX_W-1:0]  m_parent_vertex,
    output logic [CNT_W-1:0]  m_edge_count,
    output logic              m_run_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [VTX_W-1:0] vcount_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
            vcount_reg <= pwdata[VTX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VTX_W){1'b0}}, vcount_reg}
                                                  : 32'd0;

    gdfs_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .status, .cmd);

    gdfs_datapath u_datapath (
        .aclk, .aresetn, .cmd, .status,
        .vertex_count(vcount_reg),
        .s_mode, .s_first_vertex, .s_second_vertex, .s_order_last,
        .m_ready, .m_valid, .m_status, .m_vertex, .m_discover_time,
        .m_finish_time, .m_parent_vertex, .m_edge_count, .m_run_last);

endmodule

@@ rtl/gdfs_checker.sv @@
// Port-level checks for the depth-first search block, bound to the top level.
module gdfs_checker import gdfs_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_status,
    input logic [VTX_W-1:0]  m_vertex,
    input logic [VTX_W-1:0]  m_parent_vertex,
    input logic              m_run_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex) && $stable(m_status))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_run_last)
        else $error("error transaction without run_last");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_vertex == '0 && m_parent_vertex == '0)
        else $error("error transaction carries a vertex");

    a_ok_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_vertex != '0
            && m_vertex <= VTX_W'(MAX_VERTICES) && m_parent_vertex != m_vertex)
        else $error("bad vertex in result");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind graph_depth_first_search gdfs_checker u_gdfs_checker (.*);
